[rtl/http_request_framer_assert.svh]
// Assertion macros used by the framer RTL.
`ifndef HTTP_REQUEST_FRAMER_ASSERT_SVH
`define HTTP_REQUEST_FRAMER_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define HRF_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hrf assertion failed");

// Next-cycle implication, checked out of reset.
`define HRF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hrf assertion failed");

`endif

[rtl/hrf_pkg.sv]
// Types, codes and match tables for the HTTP request framer.
package hrf_pkg;

    typedef enum logic [2:0] {
        CLASS_HEAD_ROOT = 3'd0,
        CLASS_GET_ROOT  = 3'd1,
        CLASS_POST_ROOT = 3'd2,
        CLASS_HEAD_LIST = 3'd3,
        CLASS_GET_LIST  = 3'd4,
        CLASS_NOT_FOUND = 3'd5
    } hrf_class_t;

    typedef enum logic [1:0] {
        PH_KEY    = 2'd0,
        PH_SPACE  = 2'd1,
        PH_NUMBER = 2'd2,
        PH_DONE   = 2'd3
    } hrf_phase_t;

    typedef struct packed {
        logic [9:0] body_length;
        logic [9:0] header_length;
        hrf_class_t method_class;
        logic       overflow;
        logic       complete;
    } hrf_result_t;

    localparam int unsigned NUM_CAND = 5;
    localparam logic [3:0]  KEY_LEN  = 4'd15;

    localparam logic [7:0] CHAR_CR    = 8'd13;
    localparam logic [7:0] CHAR_LF    = 8'd10;
    localparam logic [7:0] CHAR_SPACE = 8'd32;
    localparam logic [7:0] CHAR_TAB   = 8'd9;
    localparam logic [7:0] CHAR_PLUS  = 8'd43;
    localparam logic [7:0] CHAR_MINUS = 8'd45;
    localparam logic [7:0] CHAR_ZERO  = 8'd48;
    localparam logic [7:0] CHAR_NINE  = 8'd57;
    localparam logic [7:0] CHAR_KEY0  = 8'd67;

    // Left-justified, padded to 16 characters; padding is never compared.
    localparam logic [127:0] CAND_TEXT [NUM_CAND] = '{
        "HEAD / HTTP/    ",
        "GET / HTTP/     ",
        "POST / HTTP/    ",
        "HEAD /list HTTP/",
        "GET /list HTTP/ "
    };
    localparam logic [4:0] CAND_LEN [NUM_CAND] = '{5'd12, 5'd11, 5'd12, 5'd16, 5'd15};
    localparam logic [127:0] KEY_TEXT = "Content-Length: ";

    function automatic logic [7:0] text_char(input logic [127:0] text, input logic [3:0] pos);
        logic [6:0] sel;
        sel = {4'd15 - pos, 3'b000};
        return text[sel +: 8];
    endfunction

endpackage

[rtl/hrf_parser.sv]
// Per-request match state and the single-pass byte update.
module hrf_parser #(
    parameter int unsigned BUFFER_BYTES = 1024
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,
    input  logic [7:0]          byte_value,
    input  logic                new_request,
    output hrf_pkg::hrf_result_t result
);
    import hrf_pkg::*;

    localparam int unsigned CW = $clog2(BUFFER_BYTES);
    localparam int unsigned VW = $clog2(BUFFER_BYTES + 1);
    localparam logic [CW-1:0] LIM = CW'(BUFFER_BYTES - 1);

    logic [CW-1:0] count_reg, count_next, b_count;
    logic [1:0]    end_stage_reg, end_stage_next, b_end_stage;
    logic [CW-1:0] hdr_off_reg, hdr_off_next, b_hdr_off;
    logic          hdr_seen_reg, hdr_seen_next, b_hdr_seen;
    logic [3:0]    key_idx_reg, key_idx_next, b_key_idx;
    hrf_phase_t    phase_reg, phase_next, b_phase;
    logic [VW-1:0] value_reg, value_next, b_value;
    logic          neg_reg, neg_next, b_neg;
    logic [4:0]    cand_reg, cand_next, b_cand;
    logic          fin_reg, fin_next, b_fin;

    logic              digit, space;
    logic [VW+3:0]     acc;
    logic [VW-1:0]     acc_sat;
    logic [CW-1:0]     hb;
    logic [VW:0]       sum;
    logic [VW-1:0]     clamped;
    logic              done, ovf;
    hrf_class_t        cls;

    // New request restarts from the reset state with this byte.
    always_comb
    begin
        b_count     = new_request ? '0 : count_reg;
        b_end_stage = new_request ? 2'd0 : end_stage_reg;
        b_hdr_off   = new_request ? '0 : hdr_off_reg;
        b_hdr_seen  = new_request ? 1'b0 : hdr_seen_reg;
        b_key_idx   = new_request ? 4'd0 : key_idx_reg;
        b_phase     = new_request ? PH_KEY : phase_reg;
        b_value     = new_request ? '0 : value_reg;
        b_neg       = new_request ? 1'b0 : neg_reg;
        b_cand      = new_request ? 5'b11111 : cand_reg;
        b_fin       = new_request ? 1'b0 : fin_reg;
    end

    assign digit = (byte_value >= CHAR_ZERO) && (byte_value <= CHAR_NINE);
    assign space = (byte_value == CHAR_SPACE) ||
                   ((byte_value >= CHAR_TAB) && (byte_value <= CHAR_CR));
    assign acc = ((VW+4)'(b_value) << 3) + ((VW+4)'(b_value) << 1)
               + (VW+4)'(byte_value - CHAR_ZERO);
    assign acc_sat = (acc > (VW+4)'(BUFFER_BYTES)) ? VW'(BUFFER_BYTES) : acc[VW-1:0];

    // Next state
    always_comb
    begin
        count_next     = b_count;
        end_stage_next = b_end_stage;
        hdr_off_next   = b_hdr_off;
        hdr_seen_next  = b_hdr_seen;
        key_idx_next   = b_key_idx;
        phase_next     = b_phase;
        value_next     = b_value;
        neg_next       = b_neg;
        cand_next      = b_cand;
        if (!b_fin)
        begin
            unique case (b_phase)
                PH_KEY:
                begin
                    if (b_key_idx < KEY_LEN && byte_value == text_char(KEY_TEXT, b_key_idx))
                    begin
                        key_idx_next = b_key_idx + 4'd1;
                        if (b_key_idx == KEY_LEN - 4'd1)
                            phase_next = PH_SPACE;
                    end
                    else
                        key_idx_next = (byte_value == CHAR_KEY0) ? 4'd1 : 4'd0;
                end
                PH_SPACE:
                begin
                    if (space)
                        phase_next = PH_SPACE;
                    else if (byte_value == CHAR_PLUS || byte_value == CHAR_MINUS)
                    begin
                        neg_next   = (byte_value == CHAR_MINUS);
                        phase_next = PH_NUMBER;
                    end
                    else if (!digit)
                        phase_next = PH_DONE;
                    else
                    begin
                        phase_next = PH_NUMBER;
                        value_next = acc_sat;
                    end
                end
                PH_NUMBER:
                begin
                    if (digit)
                        value_next = acc_sat;
                    else
                        phase_next = PH_DONE;
                end
                PH_DONE:
                    phase_next = PH_DONE;
                default:
                    phase_next = b_phase;
            endcase

            if (!b_hdr_seen)
            begin
                if (b_end_stage == 2'd3 && byte_value == CHAR_LF)
                begin
                    hdr_seen_next  = 1'b1;
                    hdr_off_next   = b_count + CW'(1);
                    end_stage_next = 2'd0;
                end
                else if (!b_end_stage[0] && byte_value == CHAR_CR)
                    end_stage_next = b_end_stage + 2'd1;
                else if (b_end_stage[0] && byte_value == CHAR_LF)
                    end_stage_next = b_end_stage + 2'd1;
                else
                    end_stage_next = (byte_value == CHAR_CR) ? 2'd1 : 2'd0;
            end

            for (int i = 0; i < NUM_CAND; i++)
            begin
                if (b_count < CW'(CAND_LEN[i]) &&
                    byte_value != text_char(CAND_TEXT[i], b_count[3:0]))
                    cand_next[i] = 1'b0;
            end

            count_next = b_count + CW'(1);
        end
    end

    // Results from the updated state
    always_comb
    begin
        hb      = hdr_seen_next ? hdr_off_next : '0;
        sum     = (VW+1)'(hb) + (VW+1)'(value_next);
        if (phase_next == PH_KEY || neg_next)
            clamped = '0;
        else if (sum > (VW+1)'(LIM))
            clamped = VW'(LIM - hb);
        else
            clamped = value_next;

        done = 1'b0;
        if (!b_fin && hdr_seen_next)
        begin
            if (phase_next == PH_KEY)
                done = 1'b1;
            else if (!(neg_next && value_next != '0))
                done = (clamped == VW'(count_next - hdr_off_next));
        end
        ovf = !b_fin && !done && (count_next >= LIM);
        fin_next = b_fin || done || ovf;

        cls = CLASS_NOT_FOUND;
        for (int i = NUM_CAND - 1; i >= 0; i--)
        begin
            if (cand_next[i] && count_next >= CW'(CAND_LEN[i]))
                cls = hrf_class_t'(3'(i));
        end

        result.complete      = done;
        result.overflow      = ovf;
        result.method_class  = cls;
        result.header_length = 10'(hb);
        result.body_length   = 10'(clamped);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            end_stage_reg <= 2'd0;
            hdr_off_reg   <= '0;
            hdr_seen_reg  <= 1'b0;
            key_idx_reg   <= 4'd0;
            phase_reg     <= PH_KEY;
            value_reg     <= '0;
            neg_reg       <= 1'b0;
            cand_reg      <= 5'b11111;
            fin_reg       <= 1'b0;
        end
        else if (step)
        begin
            count_reg     <= count_next;
            end_stage_reg <= end_stage_next;
            hdr_off_reg   <= hdr_off_next;
            hdr_seen_reg  <= hdr_seen_next;
            key_idx_reg   <= key_idx_next;
            phase_reg     <= phase_next;
            value_reg     <= value_next;
            neg_reg       <= neg_next;
            cand_reg      <= cand_next;
            fin_reg       <= fin_next;
        end
    end

endmodule

[rtl/http_request_framer.sv]
// HTTP request framer: one byte per item in, one status item per byte out.
// Registered path from input accept to result valid: input register, then result register.
// Throughput: 1 item per cycle unless m_tready stalls the output; the per-byte update is one pass of small matchers
// and a decimal multiply-by-ten accumulate.
// Reset: rst_n asynchronous, clears all match state and both valid flags.
`include "http_request_framer_assert.svh"
module http_request_framer #(
    parameter int unsigned BUFFER_BYTES = 1024
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] byte_value
    input  logic        s_tuser,   // [0] new_request
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // [0] complete, [1] overflow, [4:2] method_class,
                                   // [14:5] header_length, [24:15] body_length, rest 0
);
    import hrf_pkg::*;

    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;
    logic        in_new_reg;
    logic        out_valid_reg;
    hrf_result_t out_reg;
    hrf_result_t result;
    logic        advance, step;

    assign advance  = !out_valid_reg || m_tready;
    assign step     = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;

    hrf_parser #(
        .BUFFER_BYTES(BUFFER_BYTES)
    ) u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (step),
        .byte_value (in_byte_reg),
        .new_request(in_new_reg),
        .result     (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
                in_valid_reg <= s_tvalid;
            if (advance)
                out_valid_reg <= step;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_byte_reg <= s_tdata;
            in_new_reg  <= s_tuser;
        end
        if (step)
            out_reg <= result;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, out_reg.body_length, out_reg.header_length,
                       out_reg.method_class, out_reg.overflow, out_reg.complete};

    `HRF_ASSERT_IMP(a_done_xor_ovf, clk, rst_n, out_valid_reg, !(out_reg.complete && out_reg.overflow))
    `HRF_ASSERT_IMP(a_done_has_header, clk, rst_n, out_valid_reg && out_reg.complete, out_reg.header_length != 10'd0)
    `HRF_ASSERT_NEXT(a_stall_holds_input, clk, rst_n, in_valid_reg && !advance, in_valid_reg && $stable(in_byte_reg))

endmodule

[tb/testbench.sv]
// Self-checking testbench for the HTTP request framer: directed and random request streams against a predictor.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import hrf_pkg::*;

    localparam int BUF_BYTES   = 1024;
    localparam int CYCLE_LIMIT = 500000;
    localparam int HOLD_CYCLES = 400;

    class status_scoreboard;
        string         route_text[NUM_CAND];
        string         key_text;
        logic [9:0]    byte_count;
        logic [1:0]    crlf_stage;
        logic [9:0]    header_end;
        logic          header_seen;
        logic [3:0]    key_pos;
        hrf_phase_t    phase;
        logic [10:0]   length_value;
        logic          length_negative;
        logic [4:0]    route_alive;
        logic          finished;
        hrf_result_t   expected_status[$];
        int            errors;
        int            checked;
        int            completes;
        int            overflows;

        function new();
            route_text = '{"HEAD / HTTP/", "GET / HTTP/", "POST / HTTP/",
                           "HEAD /list HTTP/", "GET /list HTTP/"};
            key_text = "Content-Length:";
            clear_state();
        endfunction

        function void clear_state();
            byte_count      = '0;
            crlf_stage      = '0;
            header_end      = '0;
            header_seen     = 1'b0;
            key_pos         = '0;
            phase           = PH_KEY;
            length_value    = '0;
            length_negative = 1'b0;
            route_alive     = 5'b11111;
            finished        = 1'b0;
        endfunction

        function bit is_blank(logic [7:0] b);
            return b == CHAR_SPACE || (b >= CHAR_TAB && b <= CHAR_CR);
        endfunction

        function void track_length(logic [7:0] b);
            bit digit;
            int v;
            digit = b >= CHAR_ZERO && b <= CHAR_NINE;
            if (phase == PH_KEY)
            begin
                if (key_pos < KEY_LEN && b == key_text[key_pos])
                begin
                    key_pos++;
                    if (key_pos == KEY_LEN)
                        phase = PH_SPACE;
                end
                else
                    key_pos = (b == CHAR_KEY0) ? 4'd1 : 4'd0;
                return;
            end
            if (phase == PH_SPACE)
            begin
                if (is_blank(b))
                    return;
                if (b == CHAR_PLUS || b == CHAR_MINUS)
                begin
                    length_negative = (b == CHAR_MINUS);
                    phase = PH_NUMBER;
                    return;
                end
                if (!digit)
                begin
                    phase = PH_DONE;
                    return;
                end
                phase = PH_NUMBER;
            end
            if (phase == PH_NUMBER)
            begin
                if (digit)
                begin
                    v = int'(length_value) * 10 + int'(b) - int'(CHAR_ZERO);
                    length_value = (v > BUF_BYTES) ? 11'(BUF_BYTES) : 11'(v);
                end
                else
                    phase = PH_DONE;
            end
        endfunction

        function void track_header_end(logic [7:0] b);
            if (header_seen)
                return;
            if (crlf_stage == 2'd3 && b == CHAR_LF)
            begin
                header_seen = 1'b1;
                header_end  = byte_count + 10'd1;
                crlf_stage  = '0;
                return;
            end
            if (!crlf_stage[0] && b == CHAR_CR)
                crlf_stage++;
            else if (crlf_stage[0] && b == CHAR_LF)
                crlf_stage++;
            else
                crlf_stage = (b == CHAR_CR) ? 2'd1 : 2'd0;
        endfunction

        function void track_route(logic [7:0] b);
            for (int i = 0; i < NUM_CAND; i++)
                if (byte_count < route_text[i].len() && b != route_text[i][byte_count])
                    route_alive[i] = 1'b0;
        endfunction

        function hrf_class_t route_class();
            for (int i = 0; i < NUM_CAND; i++)
                if (route_alive[i] && byte_count >= route_text[i].len())
                    return hrf_class_t'(i);
            return CLASS_NOT_FOUND;
        endfunction

        // Declared body length, clamped to what is left of the buffer.
        function int body_limit();
            int lim;
            int hb;
            int v;
            lim = BUF_BYTES - 1;
            hb  = header_seen ? int'(header_end) : 0;
            v   = int'(length_value);
            if (phase == PH_KEY || length_negative)
                return 0;
            if (hb > lim)
                hb = lim;
            if (hb + v > lim)
                v = lim - hb;
            return v;
        endfunction

        function void take_byte(logic [7:0] b, logic start);
            hrf_result_t r;
            logic done;
            logic ovf;
            done = 1'b0;
            ovf  = 1'b0;
            if (start)
                clear_state();
            if (!finished)
            begin
                track_length(b);
                track_header_end(b);
                track_route(b);
                byte_count++;
                if (header_seen)
                begin
                    if (phase == PH_KEY)
                        done = 1'b1;
                    else if (!(length_negative && length_value != 0))
                        done = (body_limit() == int'(byte_count) - int'(header_end));
                end
                if (!done && byte_count >= BUF_BYTES - 1)
                    ovf = 1'b1;
                if (done || ovf)
                    finished = 1'b1;
            end
            r.complete      = done;
            r.overflow      = ovf;
            r.method_class  = route_class();
            r.header_length = header_seen ? header_end : 10'd0;
            r.body_length   = 10'(body_limit());
            completes += done;
            overflows += ovf;
            expected_status.push_back(r);
        endfunction

        function void fail_note(string msg);
            errors++;
            if (errors <= 10)
                $display("%s", msg);
        endfunction

        function void check_status(logic [31:0] word);
            hrf_result_t want;
            hrf_result_t got;
            checked++;
            got = hrf_result_t'(word[24:0]);
            if (expected_status.size() == 0)
            begin
                fail_note($sformatf("unexpected result %h with nothing pending", word));
                return;
            end
            want = expected_status.pop_front();
            if (got.complete !== want.complete || got.overflow !== want.overflow ||
                got.method_class !== want.method_class ||
                got.header_length !== want.header_length ||
                got.body_length !== want.body_length || word[31:25] !== 7'd0)
                fail_note($sformatf({"result %0d: exp cmp=%0b ovf=%0b cls=%0d hdr=%0d body=%0d,",
                                     " got cmp=%0b ovf=%0b cls=%0d hdr=%0d body=%0d pad=%h"},
                                    checked, want.complete, want.overflow, want.method_class,
                                    want.header_length, want.body_length, got.complete,
                                    got.overflow, got.method_class, got.header_length,
                                    got.body_length, word[31:25]));
        endfunction

        function void check_drained();
            if (expected_status.size() != 0)
                fail_note($sformatf("%0d results never arrived", expected_status.size()));
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;

    status_scoreboard sb = new();
    logic [7:0] req_bytes[$];
    int         sent_items;
    int         requests;
    int         burst_left;
    int         cycles;

    http_request_framer dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("Regression FAIL");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                sb.take_byte(s_tdata, s_tuser);
            if (m_tvalid && m_tready)
                sb.check_status(m_tdata);
        end
    end

    // Receiver: changing stall patterns, plus one long hold-off to back up the block.
    initial
    begin
        int mode;
        int mode_left;
        int phase_cnt;
        bit held;
        m_tready  = 1'b0;
        mode      = 0;
        mode_left = 0;
        phase_cnt = 0;
        held      = 1'b0;
        forever
        begin
            @(negedge clk);
            if (!held && sb.checked >= 400)
            begin
                held = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            else
            begin
                if (mode_left == 0)
                begin
                    mode      = $urandom_range(0, 3);
                    mode_left = $urandom_range(50, 300);
                end
                mode_left--;
                phase_cnt++;
                case (mode)
                    0: m_tready <= 1'b1;
                    1: m_tready <= 1'($urandom_range(0, 1));
                    2: m_tready <= (phase_cnt % 3 == 0);
                    default: m_tready <= ($urandom_range(0, 9) != 0);
                endcase
            end
        end
    end

    function automatic void add_byte(logic [7:0] b);
        req_bytes.push_back(b);
    endfunction

    function automatic void add_text(string s);
        for (int i = 0; i < s.len(); i++)
            req_bytes.push_back(s[i]);
    endfunction

    function automatic void add_length_key();
        if ($urandom_range(0, 4) == 0)
            add_text("Content-Len");
        add_text("Content-Length:");
        repeat ($urandom_range(0, 3))
            add_byte($urandom_range(0, 1) ? CHAR_SPACE : CHAR_TAB);
    endfunction

    function automatic void build_request();
        string routes[NUM_CAND];
        int    pick;
        int    len_kind;
        int    value;
        int    body_bytes;
        routes = '{"HEAD / HTTP/", "GET / HTTP/", "POST / HTTP/",
                   "HEAD /list HTTP/", "GET /list HTTP/"};
        req_bytes.delete();
        if ($urandom_range(0, 9) == 0)
        begin
            repeat ($urandom_range(1, 30))
                add_byte(8'($urandom_range(0, 255)));
            return;
        end
        pick = $urandom_range(0, 9);
        if (pick <= 7)
        begin
            add_text(routes[$urandom_range(0, NUM_CAND - 1)]);
            if (pick == 7)
                req_bytes[$urandom_range(0, req_bytes.size() - 1)] = 8'($urandom_range(0, 255));
        end
        else if (pick == 8)
        begin
            value = $urandom_range(0, NUM_CAND - 1);
            add_text(routes[value].substr(0, $urandom_range(0, routes[value].len() - 2)));
            add_byte(8'($urandom_range(97, 122)));
        end
        else
            repeat ($urandom_range(1, 6))
                add_byte(8'($urandom_range(32, 126)));
        add_text($sformatf("1.%0d\r\n", $urandom_range(0, 1)));
        repeat ($urandom_range(0, 3))
        begin
            add_text("X-");
            repeat ($urandom_range(1, 6))
                add_byte(8'($urandom_range(97, 122)));
            add_text(": ");
            repeat ($urandom_range(0, 8))
                add_byte(8'($urandom_range(33, 126)));
            add_text("\r\n");
        end
        value    = 0;
        len_kind = $urandom_range(0, 9);
        case (len_kind)
            2, 3, 4, 5:
            begin
                value = $urandom_range(0, 40);
                add_length_key();
                if ($urandom_range(0, 3) == 0)
                    add_text("+");
                if ($urandom_range(0, 5) == 0)
                    add_text("0");
                add_text($sformatf("%0d", value));
            end
            6:
            begin
                add_length_key();
                if ($urandom_range(0, 2) == 0)
                    add_text("-0");
                else
                    add_text($sformatf("-%0d", $urandom_range(1, 50)));
            end
            7:
            begin
                add_length_key();
                case ($urandom_range(0, 3))
                    0: add_text("+");
                    1: add_text("-");
                    2: add_text("abc");
                    default: ;
                endcase
            end
            8:
            begin
                value = $urandom_range(1000, 99999);
                add_length_key();
                add_text($sformatf("%0d", value));
                value = $urandom_range(0, 20);
            end
            default: ;
        endcase
        if (len_kind >= 2 && len_kind <= 8)
            add_text("\r\n");
        add_text("\r\n");
        if (len_kind >= 2 && len_kind <= 5)
            body_bytes = ($urandom_range(0, 3) == 0) ? $urandom_range(0, value + 4)
                                                     : value + $urandom_range(0, 3);
        else
            body_bytes = $urandom_range(0, 12);
        // Length key that only shows up in the body.
        if (len_kind == 9)
            add_text($sformatf("Content-Length: %0d\r\n", $urandom_range(0, 9)));
        repeat (body_bytes)
            add_byte(8'($urandom_range(0, 255)));
        if ($urandom_range(0, 7) == 0)
            req_bytes[$urandom_range(0, req_bytes.size() - 1)] = 8'($urandom_range(0, 255));
    endfunction

    // Called at a falling edge; returns at the falling edge after the item is taken.
    task automatic send_item(input logic [7:0] b, input logic start);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 60);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= start;
        do
            @(posedge clk);
        while (!s_tready);
        sent_items++;
        @(negedge clk);
    endtask

    task automatic send_request(input bit mark_start);
        requests++;
        for (int i = 0; i < req_bytes.size(); i++)
            send_item(req_bytes[i], mark_start && i == 0);
    endtask

    task automatic send_long(input string head);
        req_bytes.delete();
        add_text(head);
        while (req_bytes.size() < BUF_BYTES + 2)
            add_byte(8'($urandom_range(0, 255)));
        send_request(1'b1);
    endtask

    initial
    begin
        int drain;
        rst_n      = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tuser    = 1'b0;
        sent_items = 0;
        requests   = 0;
        burst_left = 0;
        cycles     = 0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Short directed pass: minimal request, ignored trailing bytes, bare header end,
        // one-byte requests at both byte extremes.
        req_bytes.delete();
        add_text("GET / HTTP/\r\n\r\n");
        send_request(1'b1);
        send_item(8'h00, 1'b0);
        send_item(8'hFF, 1'b0);
        req_bytes.delete();
        add_text("\r\n\r\n");
        send_request(1'b1);
        send_item(8'h00, 1'b1);
        send_item(8'hFF, 1'b1);

        // The two full-buffer requests below add about two buffers' worth of items.
        while (sent_items < 900)
        begin
            build_request();
            send_request($urandom_range(0, 9) != 0);
        end

        // Full buffer: saturated length completes on the last byte, negative length overflows.
        send_long("POST / HTTP/1.1\r\nContent-Length: 70000\r\n\r\n");
        send_long("HEAD /list HTTP/1.0\r\nContent-Length: -12\r\n\r\n");
        build_request();
        send_request(1'b1);
        s_tvalid <= 1'b0;

        while (sb.expected_status.size() != 0)
            @(posedge clk);
        for (drain = 0; drain < 20; drain++)
            @(posedge clk);
        sb.check_drained();

        $display("covered %0d requests in %0d bytes: %0d completed, %0d overflowed",
                 requests, sent_items, sb.completes, sb.overflows);
        $display("%0d results checked, %0d mismatches", sb.checked, sb.errors);
        if (sb.errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
